// ----- hdl/list_mode_event_parser_top_defines.svh -----
// Assertion macros shared by the list-mode event parser.
`ifndef LIST_MODE_EVENT_PARSER_TOP_DEFINES_SVH
`define LIST_MODE_EVENT_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMEP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lmep_pkg.sv -----
package lmep_pkg;

   // Parser phases within one event.
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_TLOW   = 3'd1,
      PH_THIGH  = 3'd2,
      PH_ENERGY = 3'd3,
      PH_BODY   = 3'd4,
      PH_SKIP   = 3'd5
   } phase_type;

   // Record kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_QDC    = 2'd1;
   localparam logic [1:0] KIND_TRACE  = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_OK          = 3'd0;
   localparam logic [2:0] ERR_STATISTICS  = 3'd1;
   localparam logic [2:0] ERR_BAD_HDR_LEN = 3'd2;
   localparam logic [2:0] ERR_ZERO_LEN    = 3'd3;
   localparam logic [2:0] ERR_LEN_MISMATCH = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_OVERRIDE_ENABLE = 1'b0;
   localparam logic CSR_MODULE_NUMBER   = 1'b1;

   localparam logic [15:0] SATURATED_ENERGY = 16'd32767;
   localparam logic [10:0] CRATE_WEIGHT     = 11'd100;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [2:0]  error_code;
      logic [3:0]  channel;
      logic [10:0] module_id;
      logic [47:0] timestamp;
      logic [15:0] cfd_fraction;
      logic [15:0] pulse_energy;
      logic [14:0] samples_in_trace;
      logic [2:0]  flag_bits;
      logic [31:0] payload_word;
      logic        end_of_event;
   } result_type;

endpackage

// ----- hdl/lmep_in_stage.sv -----
module lmep_in_stage (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic        advance,
   output logic        word_valid,
   output logic [31:0] word
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] word_ff;
   logic [31:0] word_in;

   // The stage can take a word when empty or when its word moves on this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         word_in  = req_data_word;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// ----- hdl/lmep_parser.sv -----
module lmep_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [31:0]         data_word,
   input  logic                override_enable,
   input  logic [7:0]          module_number,
   output logic                result_valid,
   output lmep_pkg::result_type result
);

   lmep_pkg::phase_type phase_ff, phase_in;
   logic [11:0] word_pos_ff, word_pos_in;
   logic [11:0] skip_ff, skip_in;
   logic [31:0] header_ff, header_in;
   logic [31:0] time_low_ff, time_low_in;
   logic [31:0] time_high_ff, time_high_in;

   logic [31:0] hdr;
   logic [4:0]  hl;
   logic [11:0] el;
   logic        hl_ok;
   logic [7:0]  base;
   logic [10:0] module_id;
   logic [14:0] trace_len;
   logic [13:0] trace_half;
   logic [14:0] expected_len;
   logic        partial_sums;
   logic [11:0] offset;
   logic [11:0] offset_ps;
   logic [11:0] skip_dec;
   lmep_pkg::result_type common;

   always_comb begin
      hdr          = (phase_ff == lmep_pkg::PH_HEADER) ? data_word : header_ff;
      hl           = hdr[16:12];
      el           = hdr[28:17];
      hl_ok        = (hl == 5'd4) || (hl == 5'd8) || (hl == 5'd12) || (hl == 5'd16);
      base         = override_enable ? module_number : {4'd0, hdr[7:4]};
      module_id    = {3'd0, base} + 11'(11'(hdr[11:8]) * lmep_pkg::CRATE_WEIGHT);
      trace_len    = data_word[30:16];
      trace_half   = trace_len[14:1];
      expected_len = {1'b0, trace_half} + {10'd0, hl};
      partial_sums = (hl == 5'd8) || (hl == 5'd16);
      offset       = word_pos_ff - 12'd4;
      offset_ps    = partial_sums ? offset - 12'd4 : offset;
      skip_dec     = skip_ff - 12'd1;

      common              = '0;
      common.channel      = hdr[3:0];
      common.module_id    = module_id;
      common.flag_bits    = hdr[31:29];
   end

   always_comb begin
      phase_in     = phase_ff;
      word_pos_in  = word_pos_ff;
      skip_in      = skip_ff;
      header_in    = header_ff;
      time_low_in  = time_low_ff;
      time_high_in = time_high_ff;
      result_valid = 1'b0;
      result       = common;

      case (phase_ff)
         lmep_pkg::PH_HEADER: begin
            header_in           = data_word;
            result.record_kind  = lmep_pkg::KIND_REJECT;
            result.end_of_event = 1'b1;
            word_pos_in         = 12'd0;
            if (hl == 5'd1) begin
               result_valid      = 1'b1;
               result.error_code = lmep_pkg::ERR_STATISTICS;
               skip_in           = (el > 12'd1) ? el - 12'd1 : 12'd0;
            end else if (!hl_ok) begin
               result_valid = 1'b1;
               if (el == 12'd0) begin
                  result.error_code = lmep_pkg::ERR_ZERO_LEN;
                  skip_in           = 12'd0;
               end else begin
                  result.error_code = lmep_pkg::ERR_BAD_HDR_LEN;
                  skip_in           = el - 12'd1;
               end
            end else if (el < {7'd0, hl}) begin
               result_valid      = 1'b1;
               result.error_code = lmep_pkg::ERR_LEN_MISMATCH;
               skip_in           = (el > 12'd0) ? el - 12'd1 : 12'd0;
            end
            if (result_valid) begin
               phase_in = (skip_in == 12'd0) ? lmep_pkg::PH_HEADER : lmep_pkg::PH_SKIP;
            end else begin
               skip_in     = skip_ff;
               word_pos_in = 12'd1;
               phase_in    = lmep_pkg::PH_TLOW;
            end
         end
         lmep_pkg::PH_TLOW: begin
            time_low_in = data_word;
            word_pos_in = 12'd2;
            phase_in    = lmep_pkg::PH_THIGH;
         end
         lmep_pkg::PH_THIGH: begin
            time_high_in = data_word;
            word_pos_in  = 12'd3;
            phase_in     = lmep_pkg::PH_ENERGY;
         end
         lmep_pkg::PH_ENERGY: begin
            result_valid = 1'b1;
            if (expected_len != {3'd0, el}) begin
               // Announced trace does not fit the event length.
               result.record_kind  = lmep_pkg::KIND_REJECT;
               result.error_code   = lmep_pkg::ERR_LEN_MISMATCH;
               result.end_of_event = 1'b1;
               skip_in             = el - 12'd4;
               word_pos_in         = 12'd0;
               phase_in = (skip_in == 12'd0) ? lmep_pkg::PH_HEADER : lmep_pkg::PH_SKIP;
            end else begin
               result.record_kind      = lmep_pkg::KIND_HEADER;
               result.timestamp        = {time_high_ff[15:0], time_low_ff};
               result.cfd_fraction     = time_high_ff[31:16];
               result.pulse_energy     = hdr[30] ? lmep_pkg::SATURATED_ENERGY
                                                 : data_word[15:0];
               result.samples_in_trace = trace_len;
               // Partial sums are not counted here, only QDC and trace words.
               result.end_of_event     = (hl < 5'd12) && (trace_half == 14'd0);
               if (el == 12'd4) begin
                  word_pos_in = 12'd0;
                  skip_in     = 12'd0;
                  phase_in    = lmep_pkg::PH_HEADER;
               end else begin
                  word_pos_in = 12'd4;
                  skip_in     = el - 12'd4;
                  phase_in    = lmep_pkg::PH_BODY;
               end
            end
         end
         lmep_pkg::PH_BODY: begin
            skip_in     = skip_dec;
            word_pos_in = word_pos_ff + 12'd1;
            if (!partial_sums || (offset >= 12'd4)) begin
               result_valid        = 1'b1;
               result.record_kind  = ((hl >= 5'd12) && (offset_ps < 12'd8))
                                     ? lmep_pkg::KIND_QDC : lmep_pkg::KIND_TRACE;
               result.payload_word = data_word;
               result.end_of_event = (skip_dec == 12'd0);
            end
            if (skip_dec == 12'd0) begin
               word_pos_in = 12'd0;
               phase_in    = lmep_pkg::PH_HEADER;
            end
         end
         default: begin
            skip_in     = skip_dec;
            word_pos_in = 12'd0;
            if (skip_dec == 12'd0) begin
               phase_in = lmep_pkg::PH_HEADER;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lmep_pkg::PH_HEADER;
         word_pos_ff  <= 12'd0;
         skip_ff      <= 12'd0;
         header_ff    <= 32'd0;
         time_low_ff  <= 32'd0;
         time_high_ff <= 32'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         word_pos_ff  <= word_pos_in;
         skip_ff      <= skip_in;
         header_ff    <= header_in;
         time_low_ff  <= time_low_in;
         time_high_ff <= time_high_in;
      end
   end

endmodule

// ----- hdl/lmep_out_reg.sv -----
module lmep_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 load_valid,
   input  lmep_pkg::result_type load_result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 free,
   output lmep_pkg::result_type result
);

   logic                 valid_ff;
   logic                 valid_in;
   lmep_pkg::result_type result_ff;
   lmep_pkg::result_type result_in;

   // The slot is free when empty or when its result leaves this cycle.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = load_valid;
         result_in = load_result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ----- hdl/list_mode_event_parser_top.sv -----
// List-mode event parser.
// The req channel carries one raw 32-bit list-mode word per transaction
// (req_data_word). The block splits the word stream into events and returns
// at most one result transaction on the rsp channel per input word: an event
// header after the fourth header word, one QDC value or packed trace-sample
// pair per body word, or one rejected-event record for a malformed event.
// Partial-sum words and the tail of rejected events produce no result.
// The csr port sets the module override; write it only while the block is idle.
// A word accepted into the input register is decoded while the result
// register can take its outcome, and the outcome is then loaded into the
// result register, which raises rsp_valid for words that give a result.
// Throughput: one word per cycle while the receiver does not stall, set by the
// single decode stage between the input register and the result register.
// Reset (synchronous, active high) empties both registers, returns the parser
// to expecting a header word and clears the configuration registers.
// When the receiver stalls, the result register holds its transaction, the
// decode stage waits, and req_ready drops once the input register is full.
`include "list_mode_event_parser_top_defines.svh"

module list_mode_event_parser_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [2:0]  rsp_error_code,
   output logic [3:0]  rsp_channel,
   output logic [10:0] rsp_module_id,
   output logic [47:0] rsp_timestamp,
   output logic [15:0] rsp_cfd_fraction,
   output logic [15:0] rsp_pulse_energy,
   output logic [14:0] rsp_samples_in_trace,
   output logic [2:0]  rsp_flag_bits,
   output logic [31:0] rsp_payload_word,
   output logic        rsp_end_of_event,

   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   // Configuration registers.
   logic       override_ff, override_in;
   logic [7:0] module_num_ff, module_num_in;

   always_comb begin
      override_in   = override_ff;
      module_num_in = module_num_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lmep_pkg::CSR_OVERRIDE_ENABLE: override_in   = csr_write_data[0];
            lmep_pkg::CSR_MODULE_NUMBER:   module_num_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         override_ff   <= 1'b0;
         module_num_ff <= 8'd0;
      end else begin
         override_ff   <= override_in;
         module_num_ff <= module_num_in;
      end
   end

   // Pipeline: input register, decode, result register.
   logic                 word_valid;
   logic [31:0]          word;
   logic                 out_free;
   logic                 advance;
   logic                 result_valid;
   lmep_pkg::result_type decoded;
   lmep_pkg::result_type rsp_result;

   // A word is decoded only when the result register can take its outcome.
   assign advance = word_valid && out_free;

   lmep_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_word (req_data_word),
      .advance       (advance),
      .word_valid    (word_valid),
      .word          (word)
   );

   lmep_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .data_word       (word),
      .override_enable (override_ff),
      .module_number   (module_num_ff),
      .result_valid    (result_valid),
      .result          (decoded)
   );

   lmep_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .load_valid  (result_valid),
      .load_result (decoded),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .free        (out_free),
      .result      (rsp_result)
   );

   assign rsp_record_kind      = rsp_result.record_kind;
   assign rsp_error_code       = rsp_result.error_code;
   assign rsp_channel          = rsp_result.channel;
   assign rsp_module_id        = rsp_result.module_id;
   assign rsp_timestamp        = rsp_result.timestamp;
   assign rsp_cfd_fraction     = rsp_result.cfd_fraction;
   assign rsp_pulse_energy     = rsp_result.pulse_energy;
   assign rsp_samples_in_trace = rsp_result.samples_in_trace;
   assign rsp_flag_bits        = rsp_result.flag_bits;
   assign rsp_payload_word     = rsp_result.payload_word;
   assign rsp_end_of_event     = rsp_result.end_of_event;

   // A stalled result must block the decode stage.
   `LMEP_ASSERT_SAME(a_stall_blocks_decode, clock, reset, rsp_valid && !rsp_ready, !advance, "decode advanced over a stalled result")

   // A word waiting for the decode stage is held in the input register.
   `LMEP_ASSERT_NEXT(a_input_held, clock, reset, word_valid && !advance, word_valid && $stable(word), "input word lost while waiting")

   // A rejected event always closes the event and carries a nonzero code.
   `LMEP_ASSERT_SAME(a_reject_closes, clock, reset, rsp_valid && (rsp_record_kind == lmep_pkg::KIND_REJECT), rsp_end_of_event && (rsp_error_code != lmep_pkg::ERR_OK), "rejected result without end of event or code")

   // Accepted results carry no error code.
   `LMEP_ASSERT_SAME(a_ok_no_code, clock, reset, rsp_valid && (rsp_record_kind != lmep_pkg::KIND_REJECT), rsp_error_code == lmep_pkg::ERR_OK, "error code on an accepted result")

endmodule

// ----- tb/sv/lmep_record_checker.sv -----
`timescale 1ns / 100ps

// Watches the word and record channels of the list-mode event parser, predicts
// the records from the accepted words and compares them in order.
module lmep_record_checker
   import lmep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_data_word,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_record_kind,
   input  logic [2:0]  rsp_error_code,
   input  logic [3:0]  rsp_channel,
   input  logic [10:0] rsp_module_id,
   input  logic [47:0] rsp_timestamp,
   input  logic [15:0] rsp_cfd_fraction,
   input  logic [15:0] rsp_pulse_energy,
   input  logic [14:0] rsp_samples_in_trace,
   input  logic [2:0]  rsp_flag_bits,
   input  logic [31:0] rsp_payload_word,
   input  logic        rsp_end_of_event,

   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data,

   output int          mismatch_count,
   output int          pending_results,
   output int          records_checked,
   output int          header_records,
   output int          qdc_records,
   output int          trace_records,
   output int          reject_records
);

   result_type  expected_records[$];

   phase_type   parse_phase;
   logic [11:0] word_position;
   logic [11:0] skip_remaining;
   logic [31:0] header_word;
   logic [31:0] time_low_word;
   logic [31:0] time_high_word;
   logic        override_enable;
   logic [7:0]  override_module;

   int          mismatches;
   int          checked;
   int          count_by_kind [4];

   // Fields that every record of an event carries: channel, module and flags.
   function automatic result_type event_identity(input logic [31:0] h);
      result_type  r;
      logic [10:0] base;
      r = '0;
      base = override_enable ? {3'b000, override_module} : {7'd0, h[7:4]};
      r.channel   = h[3:0];
      r.module_id = base + CRATE_WEIGHT * {7'd0, h[11:8]};
      r.flag_bits = h[31:29];
      return r;
   endfunction

   function automatic result_type rejected_event(input logic [31:0] h, input logic [2:0] code);
      result_type r;
      r = event_identity(h);
      r.record_kind  = KIND_REJECT;
      r.error_code   = code;
      r.end_of_event = 1'b1;
      return r;
   endfunction

   task automatic skip_rest(input logic [11:0] n);
      skip_remaining = n;
      word_position  = '0;
      if (n == 0) parse_phase = PH_HEADER;
      else parse_phase = PH_SKIP;
   endtask

   // Advances the parser by one word and gives the record it causes, if any.
   task automatic decode_word(input logic [31:0] w, output bit produced, output result_type r);
      logic [4:0]  hl;
      logic [11:0] el;
      logic [14:0] tl;
      logic [15:0] energy;
      logic [11:0] offset;
      logic [11:0] psum_words;
      int          trace_pairs;
      int          following;
      produced = 1'b0;
      r = '0;
      hl = header_word[16:12];
      el = header_word[28:17];
      case (parse_phase)
         PH_HEADER: begin
            header_word = w;
            hl = w[16:12];
            el = w[28:17];
            produced = 1'b1;
            if (hl == 5'd1) begin
               skip_rest(el > 1 ? el - 12'd1 : 12'd0);
               r = rejected_event(w, ERR_STATISTICS);
            end else if (hl != 5'd4 && hl != 5'd8 && hl != 5'd12 && hl != 5'd16) begin
               if (el == 0) begin
                  skip_rest(12'd0);
                  r = rejected_event(w, ERR_ZERO_LEN);
               end else begin
                  skip_rest(el - 12'd1);
                  r = rejected_event(w, ERR_BAD_HDR_LEN);
               end
            end else if (el < hl) begin
               skip_rest(el > 0 ? el - 12'd1 : 12'd0);
               r = rejected_event(w, ERR_LEN_MISMATCH);
            end else begin
               produced      = 1'b0;
               word_position = 12'd1;
               parse_phase   = PH_TLOW;
            end
         end
         PH_TLOW: begin
            time_low_word = w;
            word_position = 12'd2;
            parse_phase   = PH_THIGH;
         end
         PH_THIGH: begin
            time_high_word = w;
            word_position  = 12'd3;
            parse_phase    = PH_ENERGY;
         end
         PH_ENERGY: begin
            tl          = w[30:16];
            energy      = w[15:0];
            trace_pairs = tl >> 1;
            following   = (hl >= 5'd12 ? 8 : 0) + trace_pairs;
            produced    = 1'b1;
            if (trace_pairs + hl != el) begin
               skip_rest(el - 12'd4);
               r = rejected_event(header_word, ERR_LEN_MISMATCH);
            end else begin
               if (header_word[30]) energy = SATURATED_ENERGY;
               r = event_identity(header_word);
               r.record_kind      = KIND_HEADER;
               r.timestamp        = {time_high_word[15:0], time_low_word};
               r.cfd_fraction     = time_high_word[31:16];
               r.pulse_energy     = energy;
               r.samples_in_trace = tl;
               r.end_of_event     = (following == 0);
               if (el == 12'd4) begin
                  word_position  = '0;
                  skip_remaining = '0;
                  parse_phase    = PH_HEADER;
               end else begin
                  word_position  = 12'd4;
                  skip_remaining = el - 12'd4;
                  parse_phase    = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            offset         = word_position - 12'd4;
            psum_words     = (hl == 5'd8 || hl == 5'd16) ? 12'd4 : 12'd0;
            skip_remaining = skip_remaining - 12'd1;
            word_position  = word_position + 12'd1;
            // Partial-sum words come first and give no record.
            if (offset >= psum_words) begin
               offset = offset - psum_words;
               r = event_identity(header_word);
               r.record_kind  = (hl >= 5'd12 && offset < 12'd8) ? KIND_QDC : KIND_TRACE;
               r.payload_word = w;
               r.end_of_event = (skip_remaining == 0);
               produced = 1'b1;
            end
            if (skip_remaining == 0) begin
               word_position = '0;
               parse_phase   = PH_HEADER;
            end
         end
         default: begin
            skip_remaining = skip_remaining - 12'd1;
            if (skip_remaining == 0) parse_phase = PH_HEADER;
            word_position = '0;
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         mismatches = mismatches + 1;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   task automatic compare_records(input result_type want, input result_type got);
      check_field("record_kind", want.record_kind, got.record_kind);
      check_field("error_code", want.error_code, got.error_code);
      check_field("channel", want.channel, got.channel);
      check_field("module_id", want.module_id, got.module_id);
      check_field("timestamp", want.timestamp, got.timestamp);
      check_field("cfd_fraction", want.cfd_fraction, got.cfd_fraction);
      check_field("pulse_energy", want.pulse_energy, got.pulse_energy);
      check_field("samples_in_trace", want.samples_in_trace, got.samples_in_trace);
      check_field("flag_bits", want.flag_bits, got.flag_bits);
      check_field("payload_word", want.payload_word, got.payload_word);
      check_field("end_of_event", want.end_of_event, got.end_of_event);
   endtask

   initial begin
      mismatches = 0;
      checked    = 0;
      foreach (count_by_kind[k]) count_by_kind[k] = 0;
   end

   always @(posedge clock) begin : monitor
      bit         made;
      result_type want;
      result_type got;
      if (reset) begin
         expected_records.delete();
         parse_phase     = PH_HEADER;
         word_position   = '0;
         skip_remaining  = '0;
         header_word     = '0;
         time_low_word   = '0;
         time_high_word  = '0;
         override_enable = 1'b0;
         override_module = '0;
      end else begin
         // Records are retired before the word of this edge is decoded, since
         // no record can leave in the cycle its word arrives.
         if (rsp_valid && rsp_ready) begin
            got.record_kind      = rsp_record_kind;
            got.error_code       = rsp_error_code;
            got.channel          = rsp_channel;
            got.module_id        = rsp_module_id;
            got.timestamp        = rsp_timestamp;
            got.cfd_fraction     = rsp_cfd_fraction;
            got.pulse_energy     = rsp_pulse_energy;
            got.samples_in_trace = rsp_samples_in_trace;
            got.flag_bits        = rsp_flag_bits;
            got.payload_word     = rsp_payload_word;
            got.end_of_event     = rsp_end_of_event;
            if (expected_records.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: unexpected record, expected none, actual kind %0d payload 0x%0h",
                        $time, got.record_kind, got.payload_word);
            end else begin
               want = expected_records.pop_front();
               compare_records(want, got);
               checked = checked + 1;
               count_by_kind[want.record_kind] = count_by_kind[want.record_kind] + 1;
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_OVERRIDE_ENABLE) override_enable = csr_write_data[0];
            else override_module = csr_write_data;
         end
         if (req_valid && req_ready) begin
            decode_word(req_data_word, made, want);
            if (made) expected_records.push_back(want);
         end
      end
      mismatch_count  <= mismatches;
      pending_results <= expected_records.size();
      records_checked <= checked;
      header_records  <= count_by_kind[KIND_HEADER];
      qdc_records     <= count_by_kind[KIND_QDC];
      trace_records   <= count_by_kind[KIND_TRACE];
      reject_records  <= count_by_kind[KIND_REJECT];
   end

endmodule

// ----- tb/sv/tb_list_mode_event_parser_top.sv -----
`timescale 1ns / 100ps

// Testbench top for the list-mode event parser. This module only makes
// stimulus and gives the verdict; the record checker instantiated beside the
// block watches both channels, predicts every record and counts mismatches.
module tb_list_mode_event_parser_top;
   import lmep_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_WORDS    = 1400;
   localparam int SETTING_COUNT   = 5;
   // The drain time covers the words that cause no record and may still be in
   // flight in the input register or the result register.
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 80;

   // Every input of the block starts at a known value.
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [31:0] req_data_word    = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [1:0]  rsp_record_kind;
   logic [2:0]  rsp_error_code;
   logic [3:0]  rsp_channel;
   logic [10:0] rsp_module_id;
   logic [47:0] rsp_timestamp;
   logic [15:0] rsp_cfd_fraction;
   logic [15:0] rsp_pulse_energy;
   logic [14:0] rsp_samples_in_trace;
   logic [2:0]  rsp_flag_bits;
   logic [31:0] rsp_payload_word;
   logic        rsp_end_of_event;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = CSR_OVERRIDE_ENABLE;
   logic [7:0]  csr_write_data   = '0;

   int          mismatch_count;
   int          pending_results;
   int          records_checked;
   int          header_records;
   int          qdc_records;
   int          trace_records;
   int          reject_records;

   // Idle control. The sender's gap switch is private to the stimulus process;
   // the receiver's switch and the hold-off request are handed over with
   // nonblocking assignments so the receiver does not see them until the following edge.
   bit          tx_gaps_on       = 1'b0;
   bit          rx_stalls_on     = 1'b0;
   int          hold_requests    = 0;
   int          words_sent       = 0;

   list_mode_event_parser_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_word        (req_data_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_record_kind      (rsp_record_kind),
      .rsp_error_code       (rsp_error_code),
      .rsp_channel          (rsp_channel),
      .rsp_module_id        (rsp_module_id),
      .rsp_timestamp        (rsp_timestamp),
      .rsp_cfd_fraction     (rsp_cfd_fraction),
      .rsp_pulse_energy     (rsp_pulse_energy),
      .rsp_samples_in_trace (rsp_samples_in_trace),
      .rsp_flag_bits        (rsp_flag_bits),
      .rsp_payload_word     (rsp_payload_word),
      .rsp_end_of_event     (rsp_end_of_event),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   lmep_record_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_word        (req_data_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_record_kind      (rsp_record_kind),
      .rsp_error_code       (rsp_error_code),
      .rsp_channel          (rsp_channel),
      .rsp_module_id        (rsp_module_id),
      .rsp_timestamp        (rsp_timestamp),
      .rsp_cfd_fraction     (rsp_cfd_fraction),
      .rsp_pulse_energy     (rsp_pulse_energy),
      .rsp_samples_in_trace (rsp_samples_in_trace),
      .rsp_flag_bits        (rsp_flag_bits),
      .rsp_payload_word     (rsp_payload_word),
      .rsp_end_of_event     (rsp_end_of_event),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .mismatch_count       (mismatch_count),
      .pending_results      (pending_results),
      .records_checked      (records_checked),
      .header_records       (header_records),
      .qdc_records          (qdc_records),
      .trace_records        (trace_records),
      .reject_records       (reject_records)
   );

   // 10 ns clock period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap lengths are mostly short, sometimes medium, and now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Header word layout: flags 31..29, event length 28..17, header length
   // 16..12, crate 11..8, slot 7..4, channel 3..0.
   function automatic logic [31:0] make_header(input logic [2:0] flags, input logic [11:0] el,
                                               input logic [4:0] hl, input logic [3:0] crate,
                                               input logic [3:0] slot, input logic [3:0] chan);
      return {flags, el, hl, crate, slot, chan};
   endfunction

   // Offers one word and returns at the edge where it is accepted. When the
   // next word follows without a gap, valid simply stays high.
   task automatic send_word(input logic [31:0] w);
      int gap;
      gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent = words_sent + 1;
   endtask

   // Whatever the header says, the parser consumes exactly the event length in
   // words, or just the header word when that length is zero. Words past the
   // fourth are random body content.
   task automatic send_event(input logic [31:0] header, input logic [31:0] tlow,
                             input logic [31:0] thigh, input logic [31:0] energy_word);
      int total;
      int i;
      total = (header[28:17] == 0) ? 1 : int'(header[28:17]);
      for (i = 0; i < total; i++) begin
         case (i)
            0: send_word(header);
            1: send_word(tlow);
            2: send_word(thigh);
            3: send_word(energy_word);
            default: send_word($urandom);
         endcase
      end
   endtask

   // A consistent event: length equals header length plus half the trace.
   // Most traces are short so the run stays fast.
   task automatic send_good_event();
      logic [4:0]  hl;
      logic [14:0] tl;
      hl = 5'(4 * $urandom_range(1, 4));
      tl = ($urandom_range(0, 99) < 93) ? 15'($urandom_range(0, 24))
                                        : 15'($urandom_range(25, 300));
      send_event(make_header(3'($urandom), 12'(hl + tl / 2), hl, 4'($urandom),
                             4'($urandom), 4'($urandom)),
                 $urandom, $urandom, {1'($urandom), tl, 16'($urandom)});
   endtask

   // Mostly well-formed events with random content, the rest malformed
   // events of every kind and stray words.
   task automatic send_random_event();
      int          roll;
      logic [4:0]  hl;
      logic [11:0] el;
      logic [14:0] tl;
      logic [31:0] w;
      roll = $urandom_range(0, 99);
      hl   = 5'(4 * $urandom_range(1, 4));
      el   = '0;
      tl   = 15'($urandom);
      if (roll < 70) begin
         send_good_event();
         return;
      end else if (roll < 78) begin
         // Statistics block.
         hl = 5'd1;
         el = 12'($urandom_range(0, 6));
      end else if (roll < 83) begin
         // Header length that is not allowed, sometimes with zero length.
         do hl = 5'($urandom);
         while (hl == 5'd1 || hl == 5'd4 || hl == 5'd8 || hl == 5'd12 || hl == 5'd16);
         el = 12'($urandom_range(0, 6));
      end else if (roll < 88) begin
         // Event shorter than its own header.
         el = 12'($urandom_range(0, hl - 1));
      end else if (roll < 95) begin
         // Trace length that disagrees with the event length.
         el = 12'($urandom_range(hl, hl + 6));
         if (tl / 2 + hl == el) tl[14] = ~tl[14];
      end else begin
         // A stray word with a short length field, then zero words, each of
         // which is rejected as a zero-length event once the stray word's
         // event has been consumed. This brings the stream back in step.
         w = $urandom;
         w[28:17] = 12'($urandom_range(0, 7));
         send_word(w);
         repeat (6) send_word(32'd0);
         return;
      end
      send_event(make_header(3'($urandom), el, hl, 4'($urandom), 4'($urandom), 4'($urandom)),
                 $urandom, $urandom, {1'($urandom), tl, 16'($urandom)});
   endtask

   // Short directed sequence: field extremes and every kind of record and
   // rejection.
   task automatic run_directed();
      // Shortest good event, all-ones time and identity, saturated energy.
      send_event(make_header(3'b111, 12'd4, 5'd4, 4'hF, 4'hF, 4'hF),
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, {1'b1, 15'd0, 16'hFFFF});
      // QDC words followed by an odd-length trace whose last half sample is dropped.
      send_event(make_header(3'b000, 12'd13, 5'd12, 4'h0, 4'h0, 4'h0),
                 32'h0000_0000, 32'h0000_0000, {1'b0, 15'd3, 16'h0000});
      // Statistics blocks with zero length and with a tail to skip.
      send_event(make_header(3'b010, 12'd0, 5'd1, 4'h3, 4'h5, 4'h9), '0, '0, '0);
      send_event(make_header(3'b101, 12'd2, 5'd1, 4'hC, 4'hA, 4'h6),
                 32'hA5A5_5A5A, '0, '0);
      // Disallowed header lengths, with zero length and with length one.
      send_event(make_header(3'b100, 12'd0, 5'd31, 4'h1, 4'h2, 4'h3), '0, '0, '0);
      send_event(make_header(3'b001, 12'd1, 5'd2, 4'h7, 4'h8, 4'hE), '0, '0, '0);
      // Event shorter than its header.
      send_event(make_header(3'b011, 12'd3, 5'd16, 4'h9, 4'hB, 4'hD),
                 32'h1234_5678, 32'h8765_4321, '0);
      // Maximum trace length against a short event: mismatch after word 3.
      send_event(make_header(3'b110, 12'd5, 5'd4, 4'h2, 4'h4, 4'h8),
                 32'h0F0F_0F0F, 32'hF0F0_F0F0, {1'b0, 15'h7FFF, 16'h8000});
   endtask

   // Stops offering words and waits until every predicted record has been
   // returned, then gives words that cause no record time to leave the block.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on consecutive edges while the block is idle.
   task automatic set_config(input logic override_on, input logic [7:0] module_number);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_OVERRIDE_ENABLE;
      csr_write_data   <= {7'd0, override_on};
      @(posedge clock);
      csr_index        <= CSR_MODULE_NUMBER;
      csr_write_data   <= module_number;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver. It stalls at random when enabled, and on a hold-off request it
   // keeps ready low for a long stretch counted here, so that the block fills
   // up and pushes back on the sender.
   initial begin : receiver
      int stall_left;
      int holds_served;
      stall_left   = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = holds_served + 1;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog for a block that hangs or loses records.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d records outstanding.",
               CYCLE_LIMIT, pending_results);
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus: reset, then five module settings that include both extremes
   // of the module number with and without the override. The directed part
   // runs under the first setting, where the module id reaches its maximum.
   initial begin : stimulus
      logic       setting_override [SETTING_COUNT];
      logic [7:0] setting_module   [SETTING_COUNT];
      int         s;
      int         goal;
      setting_override[0] = 1'b1;  setting_module[0] = 8'd255;
      setting_override[1] = 1'b0;  setting_module[1] = 8'd0;
      setting_override[2] = 1'b1;  setting_module[2] = 8'd0;
      setting_override[3] = 1'b0;  setting_module[3] = 8'd255;
      setting_override[4] = 1'b1;  setting_module[4] = 8'($urandom);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (s = 0; s < SETTING_COUNT; s++) begin
         // Every phase starts from an idle block; this is also where the
         // sender pauses until all outstanding records have arrived.
         wait_drained();
         set_config(setting_override[s], setting_module[s]);
         if (s == 0) run_directed();
         if (s == 2) begin
            // Long receiver hold-off while the sender streams back to back.
            hold_requests <= hold_requests + 1;
            tx_gaps_on = 1'b0;
            repeat (6) send_good_event();
         end
         goal = words_sent + RANDOM_WORDS / SETTING_COUNT;
         while (words_sent < goal) begin
            // Idle modes change now and then, leaving stretches with no idling.
            if ($urandom_range(0, 9) == 0) begin
               tx_gaps_on = 1'($urandom_range(0, 1));
               rx_stalls_on <= 1'($urandom_range(0, 1));
            end
            send_random_event();
         end
      end

      wait_drained();
      $display("Summary: %0d words sent under %0d module settings, %0d records checked.",
               words_sent, SETTING_COUNT, records_checked);
      $display("Records by kind: %0d headers, %0d qdc, %0d trace, %0d rejected events.",
               header_records, qdc_records, trace_records, reject_records);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
